### rtl/core/snfc_pkg.sv
package snfc_pkg;

    localparam int FLASH_BYTES = 1048576;
    localparam int AW          = $clog2(FLASH_BYTES);
    localparam int CW          = AW + 1;
    localparam int CAP_CODE    = AW;

    localparam logic       OP_READ  = 1'b0;
    localparam logic       OP_WRITE = 1'b1;

    localparam logic [5:0] REG_TRANS    = 6'd0;
    localparam logic [5:0] REG_OPCODE   = 6'd1;
    localparam logic [5:0] REG_DATA_LO  = 6'd2;
    localparam logic [5:0] REG_DATA_HI  = 6'd9;
    localparam logic [5:0] REG_MASTER   = 6'd10;
    localparam logic [5:0] REG_MOREBUF  = 6'd11;
    localparam logic [5:0] REG_POLARITY = 6'd14;

    localparam logic [7:0] CMD_RDID      = 8'h9F;
    localparam logic [7:0] CMD_RES       = 8'hAB;
    localparam logic [7:0] CMD_REMS      = 8'h90;
    localparam logic [7:0] CMD_RDID_ALT  = 8'h9E;
    localparam logic [7:0] CMD_RDSR      = 8'h05;
    localparam logic [7:0] CMD_WREN      = 8'h06;
    localparam logic [7:0] CMD_WRDI      = 8'h04;
    localparam logic [7:0] CMD_READ      = 8'h03;
    localparam logic [7:0] CMD_FAST_READ = 8'h0B;
    localparam logic [7:0] CMD_PP        = 8'h02;
    localparam logic [7:0] CMD_SE_4K     = 8'h20;
    localparam logic [7:0] CMD_BE_32K    = 8'h52;
    localparam logic [7:0] CMD_BE_64K    = 8'hD8;
    localparam logic [7:0] CMD_CE        = 8'hC7;

    localparam logic [7:0] MFR_ID   = 8'hEF;
    localparam logic [7:0] TYPE_ID  = 8'h40;
    localparam logic [7:0] ALT_ID   = 8'h16;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_REQ,
        ST_RD_CAP,
        ST_PG_REQ,
        ST_PG_WR,
        ST_ERASE
    } state_t;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_READ,
        JOB_PROG,
        JOB_ERASE
    } job_t;

    typedef struct packed {
        logic          accept;
        logic          clear_wr;
        logic          rd_req;
        logic          rd_cap;
        logic          pg_wr;
        logic          er_wr;
        logic [CW-1:0] cnt;
    } ctl_t;

    typedef struct packed {
        job_t          job;
        logic [CW-1:0] len;
    } stat_t;

endpackage

### rtl/core/snfc_datapath.sv
module snfc_datapath
    import snfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op,
    input  logic [5:0]  word_index,
    input  logic [31:0] write_data,
    input  ctl_t        ctl,
    output stat_t       stat,
    output logic [31:0] read_data
);

    logic [31:0] trans_reg;
    logic [31:0] opcode_reg;
    logic [31:0] first_opcode_reg;
    logic [1:0]  opw_reg;
    logic [31:0] tx_reg [8];
    logic [31:0] rx_reg [8];
    logic [31:0] master_reg;
    logic [31:0] morebuf_reg;
    logic [31:0] polarity_reg;
    logic [7:0]  cmd_reg;
    logic        wel_reg;
    logic [31:0] rptr_reg;
    logic [31:0] base_reg;
    logic [31:0] read_data_reg;
    logic [7:0]  mem_rdata_reg;
    logic [7:0]  flash_mem [FLASH_BYTES];

    logic          start;
    logic          cmd_phase;
    logic [7:0]    cmd_sel;
    logic [31:0]   dec_addr;
    logic [5:0]    rd_n6;
    logic [5:0]    rd_len;
    logic [7:0]    pg_n8;
    logic [5:0]    pg_len;
    logic [31:0]   rd_base;
    job_t          job;
    logic [CW-1:0] job_len;
    logic [31:0]   job_base;
    logic [31:0]   id_word;
    logic          wel_next;
    logic [32:0]   sum;
    logic          in_lin;
    logic          in_wrap;
    logic [31:0]   tx_word;
    logic [7:0]    pg_byte;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [31:0]   resp;

    assign start = ctl.accept && (op == OP_WRITE) && (word_index == REG_TRANS)
                   && write_data[8];
    assign cmd_phase = |morebuf_reg[29:27];
    assign dec_addr  = {opcode_reg[23:0], tx_reg[0][7:0]};
    assign rd_n6     = morebuf_reg[20:15];
    assign rd_len    = ((rd_n6 == 6'd0) || (rd_n6 > 6'd32)) ? 6'd32 : rd_n6;
    assign pg_n8     = morebuf_reg[31:24];
    assign pg_len    = (pg_n8 == 8'd0) ? 6'd4 : ((pg_n8 > 8'd32) ? 6'd32 : pg_n8[5:0]);
    assign rd_base   = cmd_phase ? dec_addr : rptr_reg;

    always_comb
    begin
        if (!cmd_phase)
            cmd_sel = cmd_reg;
        else if (opw_reg >= 2'd2)
            cmd_sel = first_opcode_reg[7:0];
        else if (opcode_reg[7:0] != 8'd0)
            cmd_sel = opcode_reg[7:0];
        else
            cmd_sel = opcode_reg[31:24];
    end

    always_comb
    begin
        job      = JOB_NONE;
        job_len  = '0;
        job_base = dec_addr;
        id_word  = '0;
        wel_next = wel_reg;
        case (cmd_sel)
            CMD_RDID, CMD_RES:
                id_word = {8'd0, 8'(CAP_CODE), TYPE_ID, MFR_ID};
            CMD_REMS:
                id_word = {16'd0, 8'(CAP_CODE), MFR_ID};
            CMD_RDID_ALT:
                id_word = {24'd0, ALT_ID};
            CMD_RDSR:
                id_word = {30'd0, wel_reg, 1'b0};
            CMD_WREN:
                wel_next = 1'b1;
            CMD_WRDI:
                wel_next = 1'b0;
            CMD_READ, CMD_FAST_READ:
            begin
                job      = JOB_READ;
                job_len  = CW'(rd_len);
                job_base = rd_base;
            end
            CMD_PP:
            begin
                job      = wel_reg ? JOB_PROG : JOB_NONE;
                job_len  = CW'(pg_len);
                wel_next = 1'b0;
            end
            CMD_SE_4K:
            begin
                job      = wel_reg ? JOB_ERASE : JOB_NONE;
                job_len  = CW'(32'h1000);
                job_base = dec_addr & ~32'h0FFF;
                wel_next = 1'b0;
            end
            CMD_BE_32K:
            begin
                job      = wel_reg ? JOB_ERASE : JOB_NONE;
                job_len  = CW'(32'h8000);
                job_base = dec_addr & ~32'h7FFF;
                wel_next = 1'b0;
            end
            CMD_BE_64K:
            begin
                job      = wel_reg ? JOB_ERASE : JOB_NONE;
                job_len  = CW'(32'h10000);
                job_base = dec_addr & ~32'hFFFF;
                wel_next = 1'b0;
            end
            CMD_CE:
            begin
                job      = wel_reg ? JOB_ERASE : JOB_NONE;
                job_len  = CW'(FLASH_BYTES);
                job_base = '0;
                wel_next = 1'b0;
            end
            default:
                job = JOB_NONE;
        endcase
    end

    assign stat.job = start ? job : JOB_NONE;
    assign stat.len = job_len;

    assign sum     = {1'b0, base_reg} + 33'(ctl.cnt);
    assign in_lin  = sum < 33'(FLASH_BYTES);
    assign in_wrap = sum[31:0] < 32'(FLASH_BYTES);
    assign tx_word = tx_reg[ctl.cnt[4:2]];
    assign pg_byte = tx_word[{ctl.cnt[1:0], 3'b000} +: 8];

    assign mem_we    = ctl.clear_wr || (ctl.er_wr && in_lin) || (ctl.pg_wr && in_wrap);
    assign mem_waddr = ctl.clear_wr ? ctl.cnt[AW-1:0] : sum[AW-1:0];
    assign mem_wdata = ctl.pg_wr ? (mem_rdata_reg & pg_byte) : 8'hFF;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            flash_mem[mem_waddr] <= mem_wdata;
        if (ctl.rd_req)
            mem_rdata_reg <= flash_mem[sum[AW-1:0]];
    end

    always_comb
    begin
        resp = '0;
        if (op == OP_READ)
        begin
            case (word_index) inside
                REG_TRANS:                  resp = trans_reg;
                [REG_DATA_LO:REG_DATA_HI]:  resp = rx_reg[3'(word_index - REG_DATA_LO)];
                REG_MASTER:                 resp = master_reg;
                REG_MOREBUF:                resp = morebuf_reg;
                REG_POLARITY:               resp = polarity_reg;
                default:                    resp = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
            read_data_reg <= resp;
        if (start)
            base_reg <= job_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_reg        <= '0;
            opcode_reg       <= '0;
            first_opcode_reg <= '0;
            opw_reg          <= '0;
            tx_reg           <= '{default: '0};
            rx_reg           <= '{default: '0};
            master_reg       <= '0;
            morebuf_reg      <= '0;
            polarity_reg     <= '0;
            cmd_reg          <= '0;
            wel_reg          <= 1'b0;
            rptr_reg         <= '0;
        end
        else
        begin
            if (ctl.accept && (op == OP_WRITE))
            begin
                case (word_index) inside
                    REG_TRANS:
                    begin
                        trans_reg <= write_data;
                        if (write_data[8])
                        begin
                            opw_reg   <= '0;
                            cmd_reg   <= cmd_sel;
                            wel_reg   <= wel_next;
                            for (int i = 0; i < 8; i++)
                                rx_reg[i] <= (i == 0) ? id_word : 32'd0;
                            if (job == JOB_READ)
                                rptr_reg <= rd_base + 32'(rd_len);
                        end
                    end
                    REG_OPCODE:
                    begin
                        opcode_reg <= write_data;
                        if (opw_reg == 2'd0)
                            first_opcode_reg <= write_data;
                        if (opw_reg < 2'd2)
                            opw_reg <= opw_reg + 2'd1;
                    end
                    [REG_DATA_LO:REG_DATA_HI]:
                        tx_reg[3'(word_index - REG_DATA_LO)] <= write_data;
                    REG_MASTER:
                        master_reg <= write_data;
                    REG_MOREBUF:
                        morebuf_reg <= write_data;
                    REG_POLARITY:
                    begin
                        polarity_reg <= write_data;
                        opw_reg      <= '0;
                    end
                    default:
                        trans_reg <= trans_reg;
                endcase
            end
            if (ctl.rd_cap && in_lin)
                rx_reg[ctl.cnt[4:2]][{ctl.cnt[1:0], 3'b000} +: 8] <= mem_rdata_reg;
        end
    end

    assign read_data = read_data_reg;

endmodule

### rtl/core/snfc_ctrl.sv
module snfc_ctrl
    import snfc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] len_reg;
    logic [CW-1:0] len_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          accept;
    logic          last;

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept   = in_valid && in_ready;
    assign last     = cnt_reg == (len_reg - CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        out_valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        ctl            = '0;
        ctl.accept     = accept;
        ctl.cnt        = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
                if (cnt_reg == CW'(FLASH_BYTES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    len_next = stat.len;
                    case (stat.job)
                        JOB_READ:  state_next = ST_RD_REQ;
                        JOB_PROG:  state_next = ST_PG_REQ;
                        JOB_ERASE: state_next = ST_ERASE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_REQ:
            begin
                ctl.rd_req = 1'b1;
                state_next = ST_RD_CAP;
            end
            ST_RD_CAP:
            begin
                ctl.rd_cap = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                state_next = last ? ST_IDLE : ST_RD_REQ;
            end
            ST_PG_REQ:
            begin
                ctl.rd_req = 1'b1;
                state_next = ST_PG_WR;
            end
            ST_PG_WR:
            begin
                ctl.pg_wr  = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                state_next = last ? ST_IDLE : ST_PG_REQ;
            end
            ST_ERASE:
            begin
                ctl.er_wr  = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                state_next = last ? ST_IDLE : ST_ERASE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/spi_nor_flash_controller.sv
// SPI NOR flash controller register map with the flash store behind it.
// Input channel (in_valid/in_ready) carries one register access per transfer:
// op (0 read, 1 write), word_index and write_data. Output channel
// (out_valid/out_ready) returns one read_data per access; writes return zero.
// The response is registered and offered the cycle after the input transfer.
// A new access is taken only once the previous response has been taken and
// any flash job has finished, so one access is in flight at a time.
// Register accesses and commands that touch no flash end when the registered
// response is taken by the receiver. Flash jobs run one byte at a time through
// the single memory port: reads request and capture each byte (up to 32), page
// program reads, ANDs and writes back each byte, sector/block erase writes each
// byte (4K/32K/64K) and chip erase writes all FLASH_BYTES bytes.
// After reset the store is swept to 0xFF, one byte per cycle, over all
// FLASH_BYTES bytes; in_ready stays low during the sweep.
// A stalled receiver holds the response and blocks further input transfers.
module spi_nor_flash_controller
    import snfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [5:0]  word_index,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data
);

    ctl_t  ctl;
    stat_t stat;

    snfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    snfc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .word_index (word_index),
        .write_data (write_data),
        .ctl        (ctl),
        .stat       (stat),
        .read_data  (read_data)
    );

    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input accepted while response pending");

    a_response_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no response after accepted transfer");

    a_single_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.clear_wr, ctl.rd_req, ctl.rd_cap, ctl.pg_wr, ctl.er_wr, ctl.accept}))
        else $error("overlapping datapath commands");

endmodule
